/* rtl/rotate_xor_packet_cipher_macros.svh */
// Assertion macros for the rotate-xor packet cipher.
// Expect signals clk and rst in the scope of use; no other dependencies.
`ifndef ROTATE_XOR_PACKET_CIPHER_MACROS_SVH
`define ROTATE_XOR_PACKET_CIPHER_MACROS_SVH

// same-cycle implication, off during reset
`define RXPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define RXPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rxpc_pkg.sv */
// Shared types, codes and helper functions for the rotate-xor packet cipher.
// No dependencies.
package rxpc_pkg;

  localparam int ACTION_W      = 2;
  localparam int KEY_INDEX_W   = 6;
  localparam int BYTE_W        = 8;
  localparam int LENGTH_W      = 16;
  localparam int SUM_W         = 32;
  localparam int KEY_LENGTH_W  = 7;
  localparam int CFG_INDEX_W   = 2;
  localparam int ROT_W         = 3;
  localparam int WINDOW_BYTES  = 8;
  localparam int CHECK_BYTES   = 4;
  localparam int MIN_KEY_LENGTH = WINDOW_BYTES + 1;
  localparam int DIV_STEPS     = BYTE_W;

  localparam logic [ACTION_W-1:0] ACT_KEY_WRITE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_START     = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_BODY      = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_CIPHER_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH  = 2'd1;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  localparam logic [KEY_LENGTH_W-1:0] KEY_LENGTH_RESET = 7'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_HDR0,
    ST_HDR1,
    ST_BODY
  } state_t;

  typedef struct packed {
    logic key_wr;
    logic start;
    logic body_capture;
    logic div_step;
    logic load_hdr0;
    logic load_hdr1;
    logic load_body;
  } cmd_t;

  typedef struct packed {
    logic packet_open;
    logic out_free;
    logic decrypt;
  } sts_t;

  // 8 = 1 mod 7, so fold octal digits and finish with one subtract
  function automatic logic [ROT_W-1:0] mod7(input logic [BYTE_W-1:0] x);
    logic [4:0] s;
    logic [3:0] t;
    s = 5'(x[7:6]) + 5'(x[5:3]) + 5'(x[2:0]);
    t = 4'(s[4:3]) + 4'(s[2:0]);
    if (t >= 4'd7) begin
      t = t - 4'd7;
    end
    return t[ROT_W-1:0];
  endfunction

  function automatic logic [BYTE_W-1:0] rotl(input logic [BYTE_W-1:0] v,
                                             input logic [ROT_W-1:0] amt);
    logic [2*BYTE_W-1:0] w;
    w = {v, v} << amt;
    return w[2*BYTE_W-1:BYTE_W];
  endfunction

  function automatic logic [BYTE_W-1:0] rotr(input logic [BYTE_W-1:0] v,
                                             input logic [ROT_W-1:0] amt);
    logic [2*BYTE_W-1:0] w;
    w = {v, v} >> amt;
    return w[BYTE_W-1:0];
  endfunction

endpackage

/* rtl/rxpc_item_if.sv */
// Input item channel: valid/ready handshake with the item payload.
// Depends on rxpc_pkg.
interface rxpc_item_if
  import rxpc_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [ACTION_W-1:0]    action;
  logic [KEY_INDEX_W-1:0] key_index;
  logic                   key_scramble;
  logic [BYTE_W-1:0]      byte_in;
  logic [BYTE_W-1:0]      rotate_seed;
  logic [BYTE_W-1:0]      window_seed;
  logic [LENGTH_W-1:0]    body_length;

  modport source (output valid, action, key_index, key_scramble, byte_in,
                  rotate_seed, window_seed, body_length, input ready);
  modport sink (input valid, action, key_index, key_scramble, byte_in,
                rotate_seed, window_seed, body_length, output ready);
endinterface

/* rtl/rxpc_result_if.sv */
// Result channel: valid/ready handshake with the result payload.
// Depends on rxpc_pkg.
interface rxpc_result_if
  import rxpc_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_out;
  logic              last_of_packet;
  logic              checksum_match;

  modport source (output valid, byte_out, last_of_packet, checksum_match, input ready);
  modport sink (input valid, byte_out, last_of_packet, checksum_match, output ready);
endinterface

/* rtl/rxpc_cfg_if.sv */
// Configuration write channel: valid/ready with register index and data.
// Depends on rxpc_pkg.
interface rxpc_cfg_if
  import rxpc_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [CFG_INDEX_W-1:0]  index;
  logic [KEY_LENGTH_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/rxpc_ctrl.sv */
// Controller state machine: accepts transactions and sequences the datapath.
// Depends on rxpc_pkg and rotate_xor_packet_cipher_macros.svh.
`include "rotate_xor_packet_cipher_macros.svh"

module rxpc_ctrl
  import rxpc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic [ACTION_W-1:0] item_action,
  output logic                item_ready,
  input  sts_t                sts,
  output cmd_t                cmd
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  state_t           state, state_next;
  logic [CNT_W-1:0] div_count;
  logic             div_last;

  assign div_last = (div_count == CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        div_count <= div_count + 1'b1;
      end else begin
        div_count <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (item_action == ACT_START) begin
            state_next = ST_DIV;
          end else if (item_action == ACT_BODY && sts.packet_open) begin
            state_next = ST_BODY;
          end
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_next = sts.decrypt ? ST_IDLE : ST_HDR0;
        end
      end
      ST_HDR0: begin
        if (sts.out_free) state_next = ST_HDR1;
      end
      ST_HDR1: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      ST_BODY: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready       = (state == ST_IDLE);
    cmd              = '0;
    cmd.key_wr       = item_ready && item_valid && (item_action == ACT_KEY_WRITE);
    cmd.start        = item_ready && item_valid && (item_action == ACT_START);
    cmd.body_capture = item_ready && item_valid && (item_action == ACT_BODY)
                       && sts.packet_open;
    cmd.div_step     = (state == ST_DIV);
    cmd.load_hdr0    = (state == ST_HDR0) && sts.out_free;
    cmd.load_hdr1    = (state == ST_HDR1) && sts.out_free;
    cmd.load_body    = (state == ST_BODY) && sts.out_free;
  end

  `RXPC_ASSERT_NXT(a_div_runs, (state == ST_DIV) && !div_last, state == ST_DIV, "divider cut short")
  `RXPC_ASSERT_NXT(a_body_done, cmd.load_body, state == ST_IDLE, "body byte not retired")
  `RXPC_ASSERT_NXT(a_hdr_order, cmd.load_hdr0, state == ST_HDR1, "second header byte skipped")
  `RXPC_ASSERT_IMP(a_one_load, 1'b1, $onehot0({cmd.load_hdr0, cmd.load_hdr1, cmd.load_body}), "two result loads at once")

endmodule

/* rtl/rxpc_datapath.sv */
// Datapath: config registers, key store, window divider, cipher and checksum,
// result register. Depends on rxpc_pkg, the config and result interfaces and the macros.
`include "rotate_xor_packet_cipher_macros.svh"

module rxpc_datapath
  import rxpc_pkg::*;
#(
  parameter int KEY_BYTES = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [KEY_INDEX_W-1:0] key_index,
  input  logic                   key_scramble,
  input  logic [BYTE_W-1:0]      byte_in,
  input  logic [BYTE_W-1:0]      rotate_seed,
  input  logic [BYTE_W-1:0]      window_seed,
  input  logic [LENGTH_W-1:0]    body_length,
  rxpc_cfg_if.sink               cfg,
  rxpc_result_if.source          result,
  input  cmd_t                   cmd,
  output sts_t                   sts
);

  localparam int AW = $clog2(KEY_BYTES);

  // configuration
  logic                    cipher_mode;
  logic [KEY_LENGTH_W-1:0] key_length;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_mode <= MODE_ENCRYPT;
      key_length  <= KEY_LENGTH_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_CIPHER_MODE) begin
        cipher_mode <= cfg.data[0];
      end else if (cfg.index == REG_KEY_LENGTH) begin
        key_length <= cfg.data;
      end
    end
  end

  // key store
  logic [BYTE_W-1:0] key_mem [KEY_BYTES];
  logic [BYTE_W-1:0] key_q;
  logic [BYTE_W-1:0] key_wdata;
  logic [BYTE_W-1:0] kidx_mod;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;

  always_comb begin
    kidx_mod = BYTE_W'(key_index);
    for (int i = 0; i < 3; i++) begin
      if (int'(kidx_mod) >= KEY_BYTES) begin
        kidx_mod = kidx_mod - BYTE_W'(KEY_BYTES);
      end
    end
    wr_addr   = kidx_mod[AW-1:0];
    key_wdata = key_scramble ? rotr(byte_in, mod7(BYTE_W'(key_index)) + 1'b1) : byte_in;
  end

  always_ff @(posedge clk) begin
    if (cmd.key_wr) begin
      key_mem[wr_addr] <= key_wdata;
    end
    if (cmd.body_capture) begin
      key_q <= key_mem[rd_addr];
    end
  end

  // packet state
  logic [ROT_W-1:0]    rotate_amount;
  logic [BYTE_W-1:0]   div_rem;
  logic [BYTE_W-1:0]   div_quot;
  logic [BYTE_W-1:0]   div_divisor;
  logic [LENGTH_W-1:0] byte_position;
  logic [LENGTH_W-1:0] packet_length;
  logic [SUM_W-1:0]    running_sum;
  logic [SUM_W-1:0]    received_sum;
  logic                packet_open;
  logic [BYTE_W-1:0]   hdr_rotate;
  logic [BYTE_W-1:0]   hdr_window;
  logic [BYTE_W-1:0]   body_byte;

  logic [8:0]          klen;
  logic [BYTE_W:0]     div_trial;
  logic [AW-1:0]       window_base;

  assign window_base = div_rem[AW-1:0];
  assign rd_addr     = window_base + AW'(byte_position[2:0]);

  always_comb begin
    klen = 9'(key_length);
    if (klen < 9'(MIN_KEY_LENGTH)) begin
      klen = 9'(MIN_KEY_LENGTH);
    end
    if (int'(klen) > KEY_BYTES) begin
      klen = 9'(KEY_BYTES);
    end
    div_trial = {div_rem, div_quot[BYTE_W-1]};
    if (div_trial >= {1'b0, div_divisor}) begin
      div_trial = div_trial - {1'b0, div_divisor};
    end
  end

  // body byte
  logic [LENGTH_W-1:0] data_len;
  logic                is_data;
  logic                body_last;
  logic [1:0]          sum_sel;
  logic [BYTE_W-1:0]   plain;
  logic [BYTE_W-1:0]   body_res;
  logic [SUM_W-1:0]    running_next;
  logic [SUM_W-1:0]    received_next;
  logic                body_match;

  always_comb begin
    data_len      = packet_length - LENGTH_W'(CHECK_BYTES);
    is_data       = byte_position < data_len;
    body_last     = ({1'b0, byte_position} + 1'b1) >= {1'b0, packet_length};
    sum_sel       = 2'(byte_position - packet_length);
    running_next  = running_sum;
    received_next = received_sum;
    body_match    = 1'b0;
    if (cipher_mode == MODE_ENCRYPT) begin
      if (is_data) begin
        plain        = body_byte;
        running_next = running_sum + SUM_W'(body_byte);
      end else begin
        plain = running_sum[8*sum_sel +: BYTE_W];
      end
      body_res = rotl(plain, rotate_amount) ^ key_q;
    end else begin
      plain    = body_byte ^ key_q;
      body_res = rotr(plain, rotate_amount);
      if (is_data) begin
        running_next = running_sum + SUM_W'(body_res);
      end else begin
        received_next = received_sum | (SUM_W'(body_res) << (8 * sum_sel));
      end
      body_match = body_last && (running_next == received_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rotate_amount <= '0;
      div_rem       <= '0;
      byte_position <= '0;
      packet_length <= '0;
      running_sum   <= '0;
      received_sum  <= '0;
      packet_open   <= 1'b0;
    end else begin
      if (cmd.start) begin
        rotate_amount <= mod7(rotate_seed) + 1'b1;
        div_rem       <= '0;
        packet_length <= (body_length < LENGTH_W'(CHECK_BYTES)) ?
                         LENGTH_W'(CHECK_BYTES) : body_length;
        byte_position <= '0;
        running_sum   <= '0;
        received_sum  <= '0;
        packet_open   <= 1'b1;
      end else if (cmd.div_step) begin
        div_rem <= div_trial[BYTE_W-1:0];
      end else if (cmd.load_body) begin
        running_sum  <= running_next;
        received_sum <= received_next;
        if (body_last) begin
          packet_open <= 1'b0;
        end else begin
          byte_position <= byte_position + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hdr_rotate  <= rotate_seed;
      hdr_window  <= window_seed;
      div_quot    <= window_seed;
      div_divisor <= BYTE_W'(klen - 9'(WINDOW_BYTES));
    end else if (cmd.div_step) begin
      div_quot <= div_quot << 1;
    end
    if (cmd.body_capture) begin
      body_byte <= byte_in;
    end
  end

  // result register
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_hdr0 || cmd.load_hdr1 || cmd.load_body) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_hdr0) begin
      result.byte_out       <= hdr_rotate;
      result.last_of_packet <= 1'b0;
      result.checksum_match <= 1'b0;
    end else if (cmd.load_hdr1) begin
      result.byte_out       <= hdr_window;
      result.last_of_packet <= 1'b0;
      result.checksum_match <= 1'b0;
    end else if (cmd.load_body) begin
      result.byte_out       <= body_res;
      result.last_of_packet <= body_last;
      result.checksum_match <= body_match;
    end
  end

  assign result.valid    = out_valid;
  assign sts.packet_open = packet_open;
  assign sts.out_free    = !out_valid || result.ready;
  assign sts.decrypt     = (cipher_mode == MODE_DECRYPT);

  `RXPC_ASSERT_IMP(a_body_open, cmd.load_body || cmd.body_capture, packet_open, "body byte with no packet open")
  `RXPC_ASSERT_NXT(a_last_closes, cmd.load_body && body_last, !packet_open, "packet left open after last byte")

endmodule

/* rtl/rotate_xor_packet_cipher.sv */
// Key write: stored in the key store when accepted. Packet start: 8 divider steps for the key
// window base, then the two header transactions in encrypt mode.
// Body byte: the key store read and the input byte are registered on acceptance, then the
// result register is loaded once the result channel is free; result valid after that load.
// Synchronous reset clears control and packet state and restores the config
// registers; the key store is not cleared.
module rotate_xor_packet_cipher
  import rxpc_pkg::*;
#(
  parameter int KEY_BYTES = 64
) (
  input  logic          clk,
  input  logic          rst,
  rxpc_item_if.sink     item,
  rxpc_result_if.source result,
  rxpc_cfg_if.sink      cfg
);

  cmd_t cmd;
  sts_t sts;
  logic item_ready;

  assign item.ready = item_ready;

  rxpc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item.valid),
    .item_action (item.action),
    .item_ready  (item_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  rxpc_datapath #(
    .KEY_BYTES (KEY_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .key_index    (item.key_index),
    .key_scramble (item.key_scramble),
    .byte_in      (item.byte_in),
    .rotate_seed  (item.rotate_seed),
    .window_seed  (item.window_seed),
    .body_length  (item.body_length),
    .cfg          (cfg),
    .result       (result),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule
